// ----- design/zzr_pkg.sv -----
// zzr_pkg: shared widths, register indexes, command and status types and
// the small zigzag helper functions of the zigzag reorder buffer
// no dependencies
package zzr_pkg;

   localparam int WORD_W          = 32;
   localparam int DIM_W           = 4;
   localparam int PROD_W          = 2 * DIM_W;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 4;
   localparam int DEF_MAX_ROWS    = 8;
   localparam int DEF_MAX_COLUMNS = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_MODE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;   // store one input word
      logic read;   // read one element into the output register and step the walk
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic load_done;   // the word being loaded completes the matrix
      logic emit_last;   // the walk sits on the final element
   } status_type;

   // zero is taken as one, anything above the limit as the limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (v > lim) begin
         res = lim;
      end else begin
         res = v;
      end
      return res;
   endfunction

   // lowest row on anti-diagonal d
   function automatic logic [DIM_W-1:0] diag_lo(input logic [DIM_W-1:0] d,
                                                input logic [DIM_W-1:0] cols);
      logic [DIM_W:0] dp1;
      logic [DIM_W:0] res;
      dp1 = {1'b0, d} + (DIM_W+1)'(1);
      res = (dp1 > {1'b0, cols}) ? dp1 - {1'b0, cols} : '0;
      return res[DIM_W-1:0];
   endfunction

   // highest row on anti-diagonal d
   function automatic logic [DIM_W-1:0] diag_hi(input logic [DIM_W-1:0] d,
                                                input logic [DIM_W-1:0] rows);
      logic [DIM_W-1:0] rm1;
      rm1 = rows - DIM_W'(1);
      return (d < rm1) ? d : rm1;
   endfunction

   // triangular number x(x+1)/2
   function automatic logic [PROD_W-1:0] tri_num(input logic [DIM_W-1:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * (PROD_W'(x) + PROD_W'(1));
      return prod >> 1;
   endfunction

endpackage

// ----- design/zzr_ctrl.sv -----
// zzr_ctrl: load / emit state machine of the zigzag reorder buffer
// drives the datapath commands and the stream handshakes; uses zzr_pkg
module zzr_ctrl
   import zzr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      cmd.load     = req_tvalid && (state_ff == ST_LOAD);
      // the output register refills whenever it is empty or being drained
      cmd.read     = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_tready);
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      if (cmd.read) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (cmd.load && status.load_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.read && status.emit_last) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      cmd.read && status.emit_last |=> state_ff == ST_LOAD)
      else $error("walk did not return to loading after the final element");

   a_full_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.load && status.load_done |=> state_ff == ST_EMIT)
      else $error("complete matrix did not start emission");

   a_read_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> rsp_tvalid)
      else $error("element read but not presented");

   a_no_load_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !cmd.load && !req_tready)
      else $error("input taken during emission");

endmodule

// ----- design/zzr_datapath.sv -----
// zzr_datapath: element store, load counter, zigzag / raster walk,
// address generation and output register; uses zzr_pkg
module zzr_datapath
   import zzr_pkg::*;
#(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [WORD_W-1:0]     req_tdata,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [WORD_W-1:0]     rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [WORD_W-1:0] store_mem [DEPTH];
   logic [WORD_W-1:0] out_word_ff;
   logic              out_last_ff;

   logic [DIM_W-1:0]  row_count_ff, row_count_in;
   logic [DIM_W-1:0]  column_count_ff, column_count_in;
   logic              inverse_ff, inverse_in;
   logic [CNT_W-1:0]  load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0]  out_idx_ff, out_idx_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  col_ff, col_in;

   logic [DIM_W-1:0]  rows, cols;
   logic [PROD_W-1:0] total;
   logic [DIM_W-1:0]  diag, diag_nx, lo, hi, lo_nx, hi_nx, pos, row_nx;
   logic              at_end;
   logic [PROD_W-1:0] base, rank, raster, src;
   logic [ADDR_W-1:0] rd_addr;

   assign rows  = clamp_dim(row_count_ff, DIM_W'(MAX_ROWS));
   assign cols  = clamp_dim(column_count_ff, DIM_W'(MAX_COLUMNS));
   assign total = PROD_W'(rows) * PROD_W'(cols);

   assign status.load_done = (PROD_W'(load_cnt_ff) + PROD_W'(1)) >= total;
   assign status.emit_last = (PROD_W'(out_idx_ff) == total - PROD_W'(1));

   // anti-diagonal geometry of the current position
   always_comb begin
      diag    = row_ff + col_ff;
      diag_nx = diag + DIM_W'(1);
      lo      = diag_lo(diag, cols);
      hi      = diag_hi(diag, rows);
      lo_nx   = diag_lo(diag_nx, cols);
      hi_nx   = diag_hi(diag_nx, rows);
      // even diagonals climb, odd ones descend
      at_end  = diag[0] ? (row_ff == hi) : (row_ff == lo);
      pos     = diag[0] ? (row_ff - lo) : (hi - row_ff);
      row_nx  = diag_nx[0] ? lo_nx : hi_nx;
   end

   // zigzag rank of (row, col): cells on earlier diagonals plus place on this one
   always_comb begin
      base = tri_num(diag);
      if (diag >= cols) begin
         base = base - tri_num(diag - cols);
      end
      if (diag >= rows) begin
         base = base - tri_num(diag - rows);
      end
      rank    = base + PROD_W'(pos);
      raster  = PROD_W'(row_ff) * PROD_W'(cols) + PROD_W'(col_ff);
      src     = inverse_ff ? rank : raster;
      rd_addr = src[ADDR_W-1:0];
   end

   // walk step, load counter and register writes
   always_comb begin
      row_in          = row_ff;
      col_in          = col_ff;
      out_idx_in      = out_idx_ff;
      load_cnt_in     = load_cnt_ff;
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      inverse_in      = inverse_ff;
      if (cmd.load) begin
         if (status.load_done) begin
            load_cnt_in = '0;
            row_in      = '0;
            col_in      = '0;
            out_idx_in  = '0;
         end else begin
            load_cnt_in = load_cnt_ff + CNT_W'(1);
         end
      end else if (cmd.read) begin
         out_idx_in = out_idx_ff + CNT_W'(1);
         if (inverse_ff) begin
            // raster walk
            if (col_ff == cols - DIM_W'(1)) begin
               col_in = '0;
               row_in = row_ff + DIM_W'(1);
            end else begin
               col_in = col_ff + DIM_W'(1);
            end
         end else if (at_end) begin
            row_in = row_nx;
            col_in = diag_nx - row_nx;
         end else if (diag[0]) begin
            row_in = row_ff + DIM_W'(1);
            col_in = col_ff - DIM_W'(1);
         end else begin
            row_in = row_ff - DIM_W'(1);
            col_in = col_ff + DIM_W'(1);
         end
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_COUNT:    row_count_in    = csr_data;
            CSR_COLUMN_COUNT: column_count_in = csr_data;
            CSR_INVERSE_MODE: inverse_in      = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= DIM_W'(8);
         column_count_ff <= DIM_W'(8);
         inverse_ff      <= 1'b0;
         load_cnt_ff     <= '0;
         out_idx_ff      <= '0;
         row_ff          <= '0;
         col_ff          <= '0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         inverse_ff      <= inverse_in;
         load_cnt_ff     <= load_cnt_in;
         out_idx_ff      <= out_idx_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
      end
   end

   // single store, written at load and read at emission
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store_mem[load_cnt_ff[ADDR_W-1:0]] <= req_tdata;
      end
      if (cmd.read) begin
         out_word_ff <= store_mem[rd_addr];
         out_last_ff <= status.emit_last;
      end
   end

   assign rsp_tdata = out_word_ff;
   assign rsp_tlast = out_last_ff;

   a_cnt_in_store: assert property (@(posedge clock) disable iff (reset)
      PROD_W'(load_cnt_ff) < PROD_W'(DEPTH))
      else $error("load counter beyond the store");

endmodule

// ----- design/zigzag_reorder_buffer.sv -----
// zigzag_reorder_buffer: top level of the raster / zigzag matrix reorder block
// instantiates zzr_ctrl and zzr_datapath; uses zzr_pkg
//
// the block collects one matrix of rows x columns 32-bit words and sends it
// out reordered: raster in and zigzag out when inverse_mode is 0, zigzag in
// and raster out when it is 1. each input transaction stores one word; the
// transaction that completes the matrix starts emission, which delivers one
// word per cycle while the sink keeps rsp_tready high, the final word flagged
// on rsp_tlast. the single element store is written once and read once per
// word. no input is taken during emission, but loading of the next matrix
// starts while the final word still waits in the output register. dimensions
// of 0 count as 1 and values above the maxima saturate; configuration writes
// are always accepted and belong between transactions, not during emission
module zigzag_reorder_buffer
   import zzr_pkg::*;
#(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [WORD_W-1:0]     req_tdata,    // [31:0] data_word
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [WORD_W-1:0]     rsp_tdata,    // [31:0] out_word
   output logic                  rsp_tlast,    // last_of_matrix
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,    // 0 row_count, 1 column_count, 2 inverse_mode
   input  logic [CSR_DATA_W-1:0] csr_data      // register value, lowest bits used
);

   cmd_type    cmd;
   status_type status;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   zzr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   zzr_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench of the zigzag reorder buffer, raster and
// zigzag orders in both directions under random stalls on both streams
// depends on zzr_pkg and zigzag_reorder_buffer
module tb_top;
   import zzr_pkg::*;

   // index with no register behind it, writes there are ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int STORE_WORDS    = 64;
   localparam int TARGET_WORDS   = 380;
   localparam int DRAIN_CYCLES   = 20;
   localparam int CONFIG_SETTLE  = 4;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } matrix_elem_type;

   // predicts the emitted matrix from the accepted words and checks results
   class zigzag_scoreboard_type;
      logic [WORD_W-1:0]     element_words[STORE_WORDS];
      int unsigned           fill_level;
      logic [CSR_DATA_W-1:0] rows_reg;
      logic [CSR_DATA_W-1:0] cols_reg;
      logic                  inverse_reg;
      matrix_elem_type       expected_elems[$];
      int unsigned           mismatch_count;
      int unsigned           checked_count;
      int unsigned           matrix_count;

      function new();
         fill_level     = 0;
         rows_reg       = 4'd8;
         cols_reg       = 4'd8;
         inverse_reg    = 1'b0;
         mismatch_count = 0;
         checked_count  = 0;
         matrix_count   = 0;
         foreach (element_words[i]) element_words[i] = '0;
      endfunction

      // zero counts as one, anything above the maximum saturates
      function int unsigned dim_in_use(input logic [CSR_DATA_W-1:0] raw,
                                       input int unsigned limit);
         if (raw == '0) return 1;
         if (raw > limit) return limit;
         return raw;
      endfunction

      function int unsigned matrix_size();
         return dim_in_use(rows_reg, DEF_MAX_ROWS) * dim_in_use(cols_reg, DEF_MAX_COLUMNS);
      endfunction

      // words still needed before the next emission
      function int unsigned words_to_complete();
         int unsigned total;
         total = matrix_size();
         return (fill_level < total) ? total - fill_level : 1;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ROW_COUNT:    rows_reg = value;
            CSR_COLUMN_COUNT: cols_reg = value;
            CSR_INVERSE_MODE: inverse_reg = value[0];
            default: ;
         endcase
      endfunction

      // one accepted input transaction; a completed matrix queues its elements
      function void note_word(input logic [WORD_W-1:0] w);
         int unsigned rows, cols, total, rank, diag, rlo, rhi, step, r, raster, src, dst;
         logic [WORD_W-1:0] reordered[STORE_WORDS];
         matrix_elem_type elem;
         rows  = dim_in_use(rows_reg, DEF_MAX_ROWS);
         cols  = dim_in_use(cols_reg, DEF_MAX_COLUMNS);
         total = rows * cols;
         element_words[fill_level % STORE_WORDS] = w;
         fill_level = (fill_level + 1) % 128;
         if (fill_level < total) return;
         fill_level = 0;
         rank = 0;
         // even diagonals climb towards the top right, odd ones fall to the bottom left
         for (diag = 0; diag + 1 < rows + cols; diag++) begin
            rlo = (diag + 1 > cols) ? diag + 1 - cols : 0;
            rhi = (diag < rows - 1) ? diag : rows - 1;
            for (step = 0; step <= rhi - rlo; step++) begin
               r      = (diag % 2 == 0) ? rhi - step : rlo + step;
               raster = r * cols + (diag - r);
               src    = inverse_reg ? rank : raster;
               dst    = inverse_reg ? raster : rank;
               reordered[dst] = element_words[src];
               rank++;
            end
         end
         for (dst = 0; dst < total; dst++) begin
            elem.word = reordered[dst];
            elem.last = (dst == total - 1);
            expected_elems.push_back(elem);
         end
      endfunction

      function void check_result(input logic [WORD_W-1:0] w, input logic last);
         matrix_elem_type want;
         checked_count++;
         if (last) matrix_count++;
         if (expected_elems.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word %08h last %0b", w, last);
            return;
         end
         want = expected_elems.pop_front();
         if (w !== want.word || last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("mismatch on result %0d: expected word %08h last %0b, got %08h last %0b",
                        checked_count, want.word, want.last, w, last);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata = '0;      // [31:0] data_word
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [WORD_W-1:0]     rsp_tdata;           // [31:0] out_word
   logic                  rsp_tlast;           // last_of_matrix
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   zigzag_scoreboard_type sb = new();
   int unsigned words_sent = 0;
   int unsigned config_writes = 0;
   bit          sender_gapless = 1'b0;
   bit          sink_gapless = 1'b0;
   int unsigned stall_left = 0;

   zigzag_reorder_buffer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result sink: check each accepted transaction, then maybe stall a while
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tlast);
         // now and then switch between stalling and taking every word
         if ($urandom_range(0, 39) == 0) sink_gapless = !sink_gapless;
         stall_left = sink_gapless ? 0 : $urandom_range(0, 8);
         if (stall_left > 0) rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_tready <= 1'b1;
      end
   end

   // one input transaction after a random gap; tvalid stays high for the next word
   task automatic send_word(input logic [WORD_W-1:0] w);
      int unsigned gap;
      gap = sender_gapless ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      sb.note_word(w);
      words_sent++;
   endtask

   // every expected word has come out, then the last load is left to settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_elems.size() != 0) @(posedge clock);
      repeat (CONFIG_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      config_writes++;
   endtask

   // all three registers, optionally the spare index too, then release the channel
   task automatic configure(input logic [CSR_DATA_W-1:0] rows,
                            input logic [CSR_DATA_W-1:0] cols,
                            input logic [CSR_DATA_W-1:0] inverse,
                            input bit touch_spare);
      write_csr(CSR_ROW_COUNT, rows);
      write_csr(CSR_COLUMN_COUNT, cols);
      write_csr(CSR_INVERSE_MODE, inverse);
      if (touch_spare) write_csr(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly small sizes, sometimes zero, the maximum or beyond it
   function automatic logic [CSR_DATA_W-1:0] draw_dim();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick < 15) return CSR_DATA_W'($urandom_range(1, 4));
      if (pick < 18) return CSR_DATA_W'($urandom_range(5, 8));
      return CSR_DATA_W'($urandom_range(9, 15));
   endfunction

   task automatic send_random_words(input int unsigned n);
      repeat (n) send_word($urandom);
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single element matrices from zero dimensions, both extreme words
      configure(4'd0, 4'd0, 4'd0, 1'b0);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      wait_idle();
      // wide matrix forward, turns at both edges
      configure(4'd2, 4'd3, 4'd0, 1'b0);
      send_random_words(6);
      wait_idle();
      // tall matrix inverse, mode taken from the lowest data bit
      configure(4'd3, 4'd2, 4'hF, 1'b0);
      send_random_words(6);
      wait_idle();
      // oversized row count saturates, single column; spare index ignored
      configure(4'd15, 4'd1, 4'hE, 1'b1);
      send_random_words(8);
      wait_idle();

      phase = 0;
      while (words_sent < TARGET_WORDS) begin
         // full size in both modes early on, then random settings
         if (phase == 0) configure(4'd8, 4'd8, 4'd0, 1'b0);
         else if (phase == 1) configure(4'd12, 4'd9, 4'd1, 1'b0);
         else configure(draw_dim(), draw_dim(), CSR_DATA_W'($urandom),
                        $urandom_range(0, 3) == 0);
         sender_gapless = ($urandom_range(0, 3) == 0);
         n = sb.words_to_complete() + $urandom_range(0, 2) * sb.matrix_size();
         // sometimes stop mid-matrix so the next settings apply to a partial load
         if (phase > 1 && $urandom_range(0, 4) == 0) n = $urandom_range(1, n);
         send_random_words(n);
         wait_idle();
         phase++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_elems.size() != 0) begin
         sb.mismatch_count++;
         $display("%0d expected words never came out", sb.expected_elems.size());
      end
      $display("%0d words loaded over %0d settings, %0d register writes",
               words_sent, phase + 4, config_writes);
      $display("%0d words checked in %0d matrices, %0d mismatches",
               sb.checked_count, sb.matrix_count, sb.mismatch_count);
      if (sb.mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("timeout with %0d words still expected", sb.expected_elems.size());
      $display("tb_top failed");
      $finish;
   end

endmodule
